// File: rtl/tfcp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, state type and control/status structs of the two-level FIFO cache policy.
package tfcp_pkg;

  localparam int unsigned LOW_DEPTH_DEF  = 448;
  localparam int unsigned HIGH_DEPTH_DEF = 192;
  localparam int unsigned COUNT_W_DEF    = 16;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned THR_W          = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd2;

  // controller states, one-hot
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_LRD  = 11'b000_0000_0010,
    S_LCMP = 11'b000_0000_0100,
    S_HRD  = 11'b000_0000_1000,
    S_HCMP = 11'b000_0001_0000,
    S_MISS = 11'b000_0010_0000,
    S_POP  = 11'b000_0100_0000,
    S_DEM  = 11'b000_1000_0000,
    S_PRO  = 11'b001_0000_0000,
    S_APP  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // latch key, clear result flags
    logic rd_low;    // read low ring at scan index
    logic rd_high;   // read high ring at scan index
    logic cmp_low;   // compare low word, bump count on match
    logic cmp_high;  // compare high word, bump count on match
    logic idx_clr;
    logic idx_inc;
    logic rd_lhead;  // read oldest low word
    logic rd_hhead;  // read oldest high word
    logic pop;       // retire oldest low word
    logic demote;    // move oldest high word to low tail
    logic promote;   // append held word to high ring
    logic append;    // append missed key to low ring
    logic finish;    // present result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic low_match;
    logic high_match;
    logic low_last;
    logic high_last;
    logic low_full;
    logic high_full;
    logic promo;
  } stat_t;

endpackage

// File: rtl/tfcp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tfcp_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 448,
  parameter int unsigned AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/tfcp_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: scan, miss cascade and result sequencing.
module tfcp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tfcp_pkg::stat_t st,
  output tfcp_pkg::cmd_t  cmd
);
  import tfcp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_LRD;
        end
      end
      S_LRD: begin
        cmd.rd_low = 1'b1;
        state_nxt  = S_LCMP;
      end
      S_LCMP: begin
        cmd.cmp_low = 1'b1;
        if (st.low_match) begin
          state_nxt = S_DONE;
        end else if (st.low_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_HRD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_LRD;
        end
      end
      S_HRD: begin
        cmd.rd_high = 1'b1;
        state_nxt   = S_HCMP;
      end
      S_HCMP: begin
        cmd.cmp_high = 1'b1;
        if (st.high_match) begin
          state_nxt = S_DONE;
        end else if (st.high_last) begin
          state_nxt = S_MISS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_HRD;
        end
      end
      S_MISS: begin
        if (st.low_full) begin
          cmd.rd_lhead = 1'b1;
          state_nxt    = S_POP;
        end else begin
          state_nxt = S_APP;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (!st.promo) begin
          state_nxt = S_MISS;
        end else if (st.high_full) begin
          cmd.rd_hhead = 1'b1;
          state_nxt    = S_DEM;
        end else begin
          state_nxt = S_PRO;
        end
      end
      S_DEM: begin
        cmd.demote = 1'b1;
        state_nxt  = S_PRO;
      end
      S_PRO: begin
        cmd.promote = 1'b1;
        state_nxt   = S_MISS;
      end
      S_APP: begin
        cmd.append = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

// File: rtl/tfcp_dp.sv
`timescale 1ns / 1ps
// Datapath: ring memories, head/fill pointers, compare logic and result registers.
module tfcp_dp #(
  parameter int unsigned LOW_DEPTH  = tfcp_pkg::LOW_DEPTH_DEF,
  parameter int unsigned HIGH_DEPTH = tfcp_pkg::HIGH_DEPTH_DEF,
  parameter int unsigned COUNT_W    = tfcp_pkg::COUNT_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tfcp_pkg::cmd_t              cmd,
  output tfcp_pkg::stat_t             st,
  input  logic [tfcp_pkg::KEY_W-1:0]  in_access_key,
  input  logic                        cfg_we,
  input  logic [tfcp_pkg::THR_W-1:0]  cfg_data,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic                        out_evicted_valid,
  output logic [tfcp_pkg::KEY_W-1:0]  out_evicted_key,
  output logic                        out_warmed_up
);
  import tfcp_pkg::*;

  localparam int unsigned LAW  = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
  localparam int unsigned HAW  = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
  localparam int unsigned LFW  = $clog2(LOW_DEPTH + 1);
  localparam int unsigned HFW  = $clog2(HIGH_DEPTH + 1);
  localparam int unsigned IW   = (LAW > HAW) ? LAW : HAW;
  localparam int unsigned WW   = KEY_W + COUNT_W;
  localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_W) - 64'd1);
  localparam logic [LAW:0] LDEP = (LAW + 1)'(LOW_DEPTH);
  localparam logic [HAW:0] HDEP = (HAW + 1)'(HIGH_DEPTH);

  logic [THR_W-1:0]   thr_r;
  logic [KEY_W-1:0]   key_r;
  logic [IW-1:0]      idx_r;
  logic [LAW-1:0]     lhead_r;
  logic [LFW-1:0]     lfill_r;
  logic [HAW-1:0]     hhead_r;
  logic [HFW-1:0]     hfill_r;
  logic               warm_r, hit_r, ev_r;
  logic [KEY_W-1:0]   evkey_r, okey_r;
  logic [COUNT_W-1:0] ocnt_r;
  logic               ov_r, ohit_r, oev_r, owarm_r;
  logic [KEY_W-1:0]   oevkey_r;

  logic [WW-1:0]      lrd, hrd, lwd, hwd;
  logic               lwe, hwe, lre, hre;
  logic [LAW-1:0]     lwa, lra, ltail, lidx, lhead_inc;
  logic [HAW-1:0]     hwa, hra, htail, hidx, hhead_inc;
  logic [KEY_W-1:0]   lkey, hkey;
  logic [COUNT_W-1:0] lcnt, hcnt, lcnt_inc, hcnt_inc, dcnt;
  logic [31:0]        thr_eff, dem32;
  logic               locc, hocc;
  logic [LAW:0]       lsum, loff, ltsum;
  logic [HAW:0]       hsum, hoff, htsum;

  assign lidx = idx_r[LAW-1:0];
  assign hidx = idx_r[HAW-1:0];
  assign lkey = lrd[WW-1:COUNT_W];
  assign lcnt = lrd[COUNT_W-1:0];
  assign hkey = hrd[WW-1:COUNT_W];
  assign hcnt = hrd[COUNT_W-1:0];

  // effective threshold and demotion count
  always_comb begin
    thr_eff = (thr_r == '0) ? 32'd1 : 32'(thr_r);
    dem32   = thr_eff - 32'd1;
    dcnt    = (dem32 > CNT_MAX) ? CNT_MAX[COUNT_W-1:0] : dem32[COUNT_W-1:0];
    lcnt_inc = (32'(lcnt) == CNT_MAX) ? lcnt : lcnt + COUNT_W'(1);
    hcnt_inc = (32'(hcnt) == CNT_MAX) ? hcnt : hcnt + COUNT_W'(1);
  end

  // occupancy of the scanned slot: ring offset from head below fill
  always_comb begin
    loff = ({1'b0, lidx} >= {1'b0, lhead_r}) ? ({1'b0, lidx} - {1'b0, lhead_r})
                                             : ({1'b0, lidx} + LDEP - {1'b0, lhead_r});
    hoff = ({1'b0, hidx} >= {1'b0, hhead_r}) ? ({1'b0, hidx} - {1'b0, hhead_r})
                                             : ({1'b0, hidx} + HDEP - {1'b0, hhead_r});
    locc = (32'(loff) < 32'(lfill_r));
    hocc = (32'(hoff) < 32'(hfill_r));
  end

  // tail slots and advanced heads
  always_comb begin
    ltsum = (LAW + 1)'(32'(lhead_r) + 32'(lfill_r));
    ltail = (ltsum >= LDEP) ? LAW'(ltsum - LDEP) : LAW'(ltsum);
    htsum = (HAW + 1)'(32'(hhead_r) + 32'(hfill_r));
    htail = (htsum >= HDEP) ? HAW'(htsum - HDEP) : HAW'(htsum);
    lsum  = {1'b0, lhead_r} + (LAW + 1)'(1);
    lhead_inc = (lsum >= LDEP) ? '0 : lsum[LAW-1:0];
    hsum  = {1'b0, hhead_r} + (HAW + 1)'(1);
    hhead_inc = (hsum >= HDEP) ? '0 : hsum[HAW-1:0];
  end

  // status to controller
  always_comb begin
    st.low_match  = locc && (lkey == key_r);
    st.high_match = hocc && (hkey == key_r);
    st.low_last   = (32'(lidx) == LOW_DEPTH - 1);
    st.high_last  = (32'(hidx) == HIGH_DEPTH - 1);
    st.low_full   = (32'(lfill_r) >= LOW_DEPTH);
    st.high_full  = (32'(hfill_r) >= HIGH_DEPTH);
    st.promo      = (32'(lcnt) >= thr_eff);
  end

  // memory port steering
  always_comb begin
    lre = cmd.rd_low | cmd.rd_lhead;
    lra = cmd.rd_lhead ? lhead_r : lidx;
    hre = cmd.rd_high | cmd.rd_hhead;
    hra = cmd.rd_hhead ? hhead_r : hidx;
    lwe = (cmd.cmp_low & st.low_match) | cmd.demote | cmd.append;
    lwa = cmd.cmp_low ? lidx : ltail;
    lwd = cmd.cmp_low ? {key_r, lcnt_inc}
        : cmd.demote  ? {hkey, dcnt}
        :               {key_r, COUNT_W'(1)};
    hwe = (cmd.cmp_high & st.high_match) | cmd.promote;
    hwa = cmd.cmp_high ? hidx : htail;
    hwd = cmd.cmp_high ? {key_r, hcnt_inc} : {okey_r, ocnt_r};
  end

  tfcp_ram #(.WIDTH(WW), .DEPTH(LOW_DEPTH), .AW(LAW)) u_low_ram (
    .clk(clk), .we(lwe), .waddr(lwa), .wdata(lwd), .re(lre), .raddr(lra), .rdata(lrd)
  );

  tfcp_ram #(.WIDTH(WW), .DEPTH(HIGH_DEPTH), .AW(HAW)) u_high_ram (
    .clk(clk), .we(hwe), .waddr(hwa), .wdata(hwd), .re(hre), .raddr(hra), .rdata(hrd)
  );

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  // ring pointers, flags and results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhead_r <= '0;
      lfill_r <= '0;
      hhead_r <= '0;
      hfill_r <= '0;
      warm_r  <= 1'b0;
      ov_r    <= 1'b0;
      hit_r   <= 1'b0;
      ev_r    <= 1'b0;
    end else begin
      ov_r <= cmd.finish;
      if (cmd.load) begin
        hit_r <= 1'b0;
        ev_r  <= 1'b0;
      end
      if ((cmd.cmp_low & st.low_match) | (cmd.cmp_high & st.high_match)) begin
        hit_r <= 1'b1;
      end
      if (cmd.pop) begin
        lhead_r <= lhead_inc;
        lfill_r <= lfill_r - LFW'(1);
        if (!st.promo) begin
          ev_r   <= 1'b1;
          warm_r <= 1'b1;
        end
      end
      if (cmd.demote) begin
        hhead_r <= hhead_inc;
        hfill_r <= hfill_r - HFW'(1);
        lfill_r <= lfill_r + LFW'(1);
      end
      if (cmd.promote) begin
        hfill_r <= hfill_r + HFW'(1);
      end
      if (cmd.append) begin
        lfill_r <= lfill_r + LFW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_access_key;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IW'(1);
    end
    if (cmd.pop) begin
      okey_r <= lkey;
      ocnt_r <= lcnt;
      if (!st.promo) begin
        evkey_r <= lkey;
      end
    end
    if (cmd.finish) begin
      ohit_r   <= hit_r;
      oev_r    <= ev_r;
      oevkey_r <= ev_r ? evkey_r : '0;
      owarm_r  <= warm_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_hit           = ohit_r;
  assign out_evicted_valid = oev_r;
  assign out_evicted_key   = oevkey_r;
  assign out_warmed_up     = owarm_r;

`ifndef SYNTHESIS
  a_low_fill: assert property (@(posedge clk) disable iff (!rst_n)
    32'(lfill_r) <= LOW_DEPTH) else $error("low ring overfilled");
  a_high_fill: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hfill_r) <= HIGH_DEPTH) else $error("high ring overfilled");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !(ohit_r && oev_r)) else $error("hit with eviction");
  a_evict_warm: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oev_r) |-> owarm_r) else $error("eviction without warm flag");
`endif
endmodule

// File: rtl/two_level_fifo_cache_policy_top.sv
`timescale 1ns / 1ps
// Top level of the two-level FIFO cache policy: controller plus datapath.
// On start the controller scans the low ring slot by slot, then the high ring; a hit
// in either ends the scan. A miss runs eviction, promotion or promotion-with-demotion
// steps until the low ring has room, then appends the key; out_valid is registered.
// Throughput: one access at a time; the next one is accepted at the edge ending the result
// cycle. The slot-by-slot scan of both rings sets the rate; the receiver cannot stall.
// Reset (synchronous, rst_n low) empties both rings, clears warm-up, threshold = 2.
module two_level_fifo_cache_policy_top #(
  parameter int unsigned LOW_DEPTH  = tfcp_pkg::LOW_DEPTH_DEF,
  parameter int unsigned HIGH_DEPTH = tfcp_pkg::HIGH_DEPTH_DEF,
  parameter int unsigned COUNT_W    = tfcp_pkg::COUNT_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tfcp_pkg::KEY_W-1:0]  in_access_key,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic                        out_evicted_valid,
  output logic [tfcp_pkg::KEY_W-1:0]  out_evicted_key,
  output logic                        out_warmed_up,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tfcp_pkg::THR_W-1:0]  cfg_promote_threshold
);
  import tfcp_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  tfcp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .st(st), .cmd(cmd)
  );

  tfcp_dp #(.LOW_DEPTH(LOW_DEPTH), .HIGH_DEPTH(HIGH_DEPTH), .COUNT_W(COUNT_W)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_access_key(in_access_key),
    .cfg_we(cfg_valid & cfg_ready), .cfg_data(cfg_promote_threshold),
    .out_valid(out_valid), .out_hit(out_hit), .out_evicted_valid(out_evicted_valid),
    .out_evicted_key(out_evicted_key), .out_warmed_up(out_warmed_up)
  );
endmodule
